// ===== rtl/core/rpc_pkg.sv =====
// rpc_pkg: word types and fixed constants of the relation property checker
// depends on nothing; imported by every module of the block
package rpc_pkg;

	localparam int ELEM_W = 6;
	localparam int CFG_W  = 7;

	localparam logic [CFG_W-1:0] ELEMENT_COUNT_RESET = 7'd64;

	// kind codes of an input word
	localparam logic KIND_INSERT   = 1'b0;
	localparam logic KIND_EVALUATE = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [ELEM_W-1:0] first_element;
		logic [ELEM_W-1:0] second_element;
	} item_word_t;

	typedef struct packed {
		logic is_reflexive;
		logic is_symmetric;
		logic is_antisymmetric;
		logic is_transitive;
	} result_word_t;

endpackage

// ===== rtl/core/relation_property_checker.sv =====
// relation_property_checker: keeps a square boolean relation matrix, rows in a
// ram, and checks it for reflexive, symmetric, antisymmetric and transitive.
// An insert word sets pair (first_element, second_element) and gives no result;
// it reads and then writes back one row, through the read and the write port
// of the row memory. An evaluate word gives one result word after a walk over
// every pair (i, j) below n = min(element_count, MAX_ELEMENTS): row i is read
// once and held, then rows j are read one per cycle, and the item side stalls
// until the result is in the output register. Rows are cleared at reset
// through per-row valid bits, so there is no clearing pass. Inserts with an
// index at or beyond MAX_ELEMENTS are dropped without a row access. A finished
// result waits in an output register, so inserts go on while it is stalled.
// Depends on rpc_pkg and rpc_row_store.
module relation_property_checker
	import rpc_pkg::*;
#(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	// item channel
	input  logic               item_valid,
	output logic               item_stall,
	input  item_word_t         item,
	// result channel
	output logic               result_valid,
	input  logic               result_stall,
	output result_word_t       result,
	// element_count register
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_data
);

	localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int EW    = (CNT_W > ELEM_W) ? CNT_W : ELEM_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INSERT,
		ST_ROW,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                  state_q;
	logic [CFG_W-1:0]        count_q;
	logic [CNT_W-1:0]        n_q;
	logic [IDX_W-1:0]        i_q;
	logic [IDX_W-1:0]        j_q;
	logic [IDX_W-1:0]        row_q;
	logic [IDX_W-1:0]        bit_q;
	logic [MAX_ELEMENTS-1:0] row_i_q;
	result_word_t            flags_q;
	logic                    result_valid_q;
	result_word_t            result_q;

	// datapath between fsm and row store
	logic                    rd_en;
	logic [IDX_W-1:0]        rd_addr;
	logic                    wr_en;
	logic [MAX_ELEMENTS-1:0] wr_row;
	logic [MAX_ELEMENTS-1:0] rd_row;

	logic                    accept;
	logic                    is_eval;
	logic                    pair_ok;
	logic [CMP_W-1:0]        count_ext;
	logic [CMP_W-1:0]        n_cmp;
	logic [CNT_W-1:0]        n_now;
	logic [CNT_W-1:0]        j_next;
	logic [CNT_W-1:0]        i_next;
	logic                    more_j;
	logic                    more_i;
	logic [MAX_ELEMENTS-1:0] col_mask;
	logic                    hit;
	logic                    refl_fail;
	logic                    sym_fail;
	logic                    anti_fail;
	logic                    trans_fail;
	logic                    out_free;

	// handshake
	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);
	assign is_eval    = (item.kind == KIND_EVALUATE);
	assign out_free   = !result_valid_q || !result_stall;

	// pair indexes beyond the matrix are dropped
	assign pair_ok = (EW'(item.first_element) < EW'(MAX_ELEMENTS))
		&& (EW'(item.second_element) < EW'(MAX_ELEMENTS));

	// element count saturated to the matrix size
	assign count_ext = CMP_W'(count_q);
	assign n_cmp     = (count_ext > CMP_W'(MAX_ELEMENTS)) ? CMP_W'(MAX_ELEMENTS) : count_ext;
	assign n_now     = n_cmp[CNT_W-1:0];

	// walk counters
	assign j_next = CNT_W'(j_q) + CNT_W'(1);
	assign i_next = CNT_W'(i_q) + CNT_W'(1);
	assign more_j = (j_next < n_q);
	assign more_i = (i_next < n_q);

	// columns that the checks cover
	always_comb begin
		for (int k = 0; k < MAX_ELEMENTS; k++) begin
			col_mask[k] = (CNT_W'(k) < n_q);
		end
	end

	// per-pair checks: row i is held, row j has just come out of the ram
	assign hit        = row_i_q[j_q];
	assign refl_fail  = (i_q == j_q) && !row_i_q[i_q];
	assign sym_fail   = hit && !rd_row[i_q];
	assign anti_fail  = (i_q != j_q) && hit && rd_row[i_q];
	assign trans_fail = hit && |(rd_row & ~row_i_q & col_mask);

	// row memory requests
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_row  = rd_row | (MAX_ELEMENTS'(1) << bit_q);
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !is_eval && pair_ok) begin
					rd_en   = 1'b1;
					rd_addr = IDX_W'(item.first_element);
				end else if (accept && is_eval && (n_now != '0)) begin
					// first row of the walk
					rd_en   = 1'b1;
					rd_addr = '0;
				end
			end
			ST_INSERT: begin
				wr_en = 1'b1;
			end
			ST_ROW: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			ST_SCAN: begin
				if (more_j) begin
					rd_en   = 1'b1;
					rd_addr = j_next[IDX_W-1:0];
				end else if (more_i) begin
					rd_en   = 1'b1;
					rd_addr = i_next[IDX_W-1:0];
				end
			end
			ST_DONE: begin
				rd_en = 1'b0;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	rpc_row_store #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_rows (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.wr_en   (wr_en),
		.wr_addr (row_q),
		.wr_row  (wr_row),
		.rd_row  (rd_row)
	);

	// element_count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= ELEMENT_COUNT_RESET;
		end else if (cfg_we) begin
			count_q <= cfg_data;
		end
	end

	// sequencer, walk state and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			n_q            <= '0;
			i_q            <= '0;
			j_q            <= '0;
			row_q          <= '0;
			bit_q          <= '0;
			row_i_q        <= '0;
			flags_q        <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			// a new result word takes the output register as the old one leaves
			if ((state_q == ST_DONE) && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !is_eval) begin
						row_q <= IDX_W'(item.first_element);
						bit_q <= IDX_W'(item.second_element);
						if (pair_ok) begin
							state_q <= ST_INSERT;
						end
					end else if (accept) begin
						// every check starts true and is knocked down by a failing pair
						flags_q <= '1;
						n_q     <= n_now;
						i_q     <= '0;
						j_q     <= '0;
						state_q <= (n_now == '0) ? ST_DONE : ST_ROW;
					end
				end
				ST_INSERT: begin
					state_q <= ST_IDLE;
				end
				ST_ROW: begin
					row_i_q <= rd_row;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					flags_q.is_reflexive     <= flags_q.is_reflexive & ~refl_fail;
					flags_q.is_symmetric     <= flags_q.is_symmetric & ~sym_fail;
					flags_q.is_antisymmetric <= flags_q.is_antisymmetric & ~anti_fail;
					flags_q.is_transitive    <= flags_q.is_transitive & ~trans_fail;
					if (more_j) begin
						j_q <= j_next[IDX_W-1:0];
					end else if (more_i) begin
						i_q     <= i_next[IDX_W-1:0];
						j_q     <= '0;
						state_q <= ST_ROW;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// wait here until the output register is free
					if (out_free) begin
						result_q <= flags_q;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== rtl/core/rpc_ram.sv =====
// rpc_ram: generic single-port-write, single-port-read ram with registered read
// depends on rpc_pkg only by house convention
module rpc_ram
	import rpc_pkg::*;
#(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/rpc_row_store.sv =====
// rpc_row_store: relation matrix rows in one ram plus a valid bit per row
// depends on rpc_pkg and rpc_ram; a row never written reads as all zero
module rpc_row_store
	import rpc_pkg::*;
#(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  rd_en,
	input  logic [(MAX_ELEMENTS > 1 ? $clog2(MAX_ELEMENTS) : 1)-1:0] rd_addr,
	input  logic                                                  wr_en,
	input  logic [(MAX_ELEMENTS > 1 ? $clog2(MAX_ELEMENTS) : 1)-1:0] wr_addr,
	input  logic [MAX_ELEMENTS-1:0]                               wr_row,
	output logic [MAX_ELEMENTS-1:0]                               rd_row
);

	localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

	logic [MAX_ELEMENTS-1:0] valid_q;
	logic [IDX_W-1:0]        rd_addr_s1;
	logic [MAX_ELEMENTS-1:0] ram_rdata;

	rpc_ram #(
		.WIDTH (MAX_ELEMENTS),
		.DEPTH (MAX_ELEMENTS)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_row),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_addr_s1 <= '0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_addr_s1 <= rd_addr;
			end
		end
	end

	assign rd_row = valid_q[rd_addr_s1] ? ram_rdata : '0;

endmodule

// ===== rtl/core/rpc_checker.sv =====
// rpc_checker: port-level assertions for relation_property_checker
// depends on rpc_pkg; bound to the top level at the end of this file
module rpc_checker
	import rpc_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input item_word_t       item,
	input logic             result_valid,
	input logic             result_stall,
	input result_word_t     result,
	input logic             cfg_we,
	input logic [CFG_W-1:0] cfg_data
);

	logic item_acc;

	assign item_acc = item_valid && !item_stall;

	// a stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// an insert never produces a result word
	a_insert_silent: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc && (item.kind == KIND_INSERT) && !result_valid
		|=> !result_valid ##1 !result_valid)
		else $error("result word appeared after an insert");

	// an evaluation keeps the item side busy
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc && (item.kind == KIND_EVALUATE) |=> item_stall)
		else $error("item accepted during an evaluation");

	// no result word out of reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !result_valid)
		else $error("result valid during reset");

endmodule

bind relation_property_checker rpc_checker u_rpc_checker (.*);

// ===== tb/sv/relation_property_checker_test.sv =====
// relation_property_checker_test: self-checking bench for the relation property checker
// keeps its own copy of the relation matrix and predicts the four flags of each evaluate word
// depends on rpc_pkg and the relation_property_checker rtl
`timescale 1ns / 1ps

module relation_property_checker_test;
	import rpc_pkg::*;

	localparam int ROWS         = 64;
	localparam int HALF_PERIOD  = 10;
	localparam int DRAIN_CYCLES = 16;    // inserts still in flight after the last result
	localparam int TAIL_CYCLES  = 200;   // quiet time at the end for stray result words
	localparam int HOLD_CYCLES  = 3000;  // long receiver hold-off, fills the block
	localparam longint TIMEOUT_NS = 64'd60_000_000;

	// scoreboard: mirror of the relation matrix and the flag words still owed
	class relation_flag_board;
		bit [ROWS-1:0]    pairs [ROWS];
		logic [CFG_W-1:0] element_count = ELEMENT_COUNT_RESET;
		result_word_t     flags_due [$];
		int               mismatches   = 0;
		int               words_taken  = 0;
		int               flags_seen   = 0;

		function result_word_t predict_flags();
			result_word_t  f;
			int            n;
			bit [ROWS-1:0] mask;
			n    = (element_count > ROWS) ? ROWS : element_count;
			mask = (n == ROWS) ? '1 : ((64'd1 << n) - 1);
			f    = '1;
			for (int i = 0; i < n; i++) begin
				if (!pairs[i][i])
					f.is_reflexive = 1'b0;
				for (int j = 0; j < n; j++) begin
					if (pairs[i][j]) begin
						if (!pairs[j][i])
							f.is_symmetric = 1'b0;
						else if (i != j)
							f.is_antisymmetric = 1'b0;
						// row j must be a subset of row i inside the window
						if ((pairs[j] & mask & ~pairs[i]) != 0)
							f.is_transitive = 1'b0;
					end
				end
			end
			return f;
		endfunction

		function void take_word(item_word_t w);
			words_taken++;
			if (w.kind == KIND_INSERT)
				pairs[w.first_element][w.second_element] = 1'b1;
			else
				flags_due.push_back(predict_flags());
		endfunction

		function void match_flags(result_word_t got);
			result_word_t want;
			logic [3:0]   wv, gv;
			string        names [4];
			names = '{"is_reflexive", "is_symmetric", "is_antisymmetric", "is_transitive"};
			flags_seen++;
			if (flags_due.size() == 0) begin
				mismatches++;
				$display("%0t: result word %b with none expected", $time, got);
				return;
			end
			want = flags_due.pop_front();
			wv   = want;
			gv   = got;
			for (int f = 0; f < 4; f++) begin
				if (gv[3-f] !== wv[3-f]) begin
					mismatches++;
					$display("%0t: %s expected %b got %b", $time, names[f], wv[3-f], gv[3-f]);
				end
			end
		endfunction

		function int pending();
			return flags_due.size();
		endfunction
	endclass

	relation_flag_board board = new;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b1;
	logic               item_valid   = 1'b0;
	logic               item_stall;
	item_word_t         item         = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	result_word_t       result;
	logic               cfg_we       = 1'b0;
	logic [CFG_W-1:0]   cfg_data     = '0;

	int idle_pct   = 0;   // sender gap chance per cycle, percent
	int stall_pct  = 0;   // receiver stall chance per cycle, percent
	int hold_token = 0;   // bumped by the stimulus to ask for a long hold-off
	int hold_seen  = 0;
	int hold_left  = 0;

	relation_property_checker #(.MAX_ELEMENTS(ROWS)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #HALF_PERIOD clk = ~clk;
	end

	// receiver: takes result words, stalls at random or holds off for a long stretch
	always @(posedge clk) begin
		if (result_valid && !result_stall)
			board.match_flags(result);
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99, 0) < stall_pct);
		end
	end

	// offer one word, hold it until taken; valid stays up into the next word if no gap
	task automatic send_word(input item_word_t w);
		while ($urandom_range(99, 0) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item       <= w;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		board.take_word(w);
	endtask

	task automatic put_pair(input int a, input int b);
		item_word_t w;
		w.kind           = KIND_INSERT;
		w.first_element  = ELEM_W'(a);
		w.second_element = ELEM_W'(b);
		send_word(w);
	endtask

	// evaluate word; the pair fields are don't-care, so they carry random bits
	task automatic ask_flags();
		item_word_t w;
		w.kind           = KIND_EVALUATE;
		w.first_element  = ELEM_W'($urandom_range(63, 0));
		w.second_element = ELEM_W'($urandom_range(63, 0));
		send_word(w);
	endtask

	// stop offering, wait for every owed flag word, then let trailing inserts finish
	task automatic settle_idle();
		item_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_element_count(input logic [CFG_W-1:0] value);
		settle_idle();
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
		board.element_count = value;
	endtask

	// one random phase: mostly well-formed growth of the relation (upward pairs,
	// transitive closure fill, diagonals, mirrors) with noise and evaluates mixed in
	// pressure: 1 long receiver hold-off midway, 2 sender pause until drained midway
	task automatic run_phase(input logic [CFG_W-1:0] count_value, input int snd_idle,
		input int rcv_idle, input int words, input int pressure);
		int            span, sent, a, b, i, j, k, r, found, start;
		bit            pushed;
		bit [ROWS-1:0] mask, miss;
		set_element_count(count_value);
		idle_pct  = snd_idle;
		stall_pct = rcv_idle;
		span   = (count_value > ROWS) ? ROWS : count_value;
		mask   = (span == ROWS) ? '1 : ((64'd1 << span) - 1);
		sent   = 0;
		pushed = 1'b0;
		while (sent < words) begin
			if (pressure != 0 && !pushed && sent >= words / 2) begin
				pushed = 1'b1;
				if (pressure == 1)
					hold_token <= hold_token + 1;
				else
					settle_idle();
			end
			r = $urandom_range(99, 0);
			if (r < 35) begin
				// upward pair keeps the relation antisymmetric
				a = $urandom_range(span - 2, 0);
				b = $urandom_range(span - 1, a + 1);
				put_pair(a, b);
				sent++;
			end else if (r < 55) begin
				// close up to three transitive gaps found in the mirror
				found = 0;
				start = $urandom_range(span - 1, 0);
				for (int s = 0; s < span && found < 3; s++) begin
					i = (start + s) % span;
					for (j = 0; j < span && found < 3; j++) begin
						if (board.pairs[i][j]) begin
							miss = board.pairs[j] & mask & ~board.pairs[i];
							if (miss != 0) begin
								k = 0;
								while (!miss[k])
									k++;
								put_pair(i, k);
								found++;
							end
						end
					end
				end
				sent += found;
				if (found == 0) begin
					a = $urandom_range(span - 1, 0);
					put_pair(a, a);
					sent++;
				end
			end else if (r < 65) begin
				a = $urandom_range(span - 1, 0);
				put_pair(a, a);
				sent++;
			end else if (r < 72) begin
				// mirror a one-way pair: symmetry repaired, antisymmetry lost
				found = 0;
				start = $urandom_range(span - 1, 0);
				for (int s = 0; s < span && found == 0; s++) begin
					i = (start + s) % span;
					for (j = 0; j < span && found == 0; j++) begin
						if (i != j && board.pairs[i][j] && !board.pairs[j][i]) begin
							put_pair(j, i);
							found = 1;
						end
					end
				end
				if (found == 0)
					put_pair($urandom_range(span - 1, 0), $urandom_range(span - 1, 0));
				sent++;
			end else if (r < 80) begin
				// noise over the whole matrix, mostly outside the window
				put_pair($urandom_range(63, 0), $urandom_range(63, 0));
				sent++;
			end else begin
				ask_flags();
				sent++;
			end
			if ($urandom_range(99, 0) < 30) begin
				ask_flags();
				sent++;
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty relation at the reset count of 64
		ask_flags();
		// empty set, every flag holds vacuously
		set_element_count(7'd0);
		ask_flags();
		// single element, before and after its loop pair
		set_element_count(7'd1);
		ask_flags();
		put_pair(0, 0);
		ask_flags();
		// pair outside the window is stored but not looked at
		put_pair(0, 1);
		ask_flags();
		// two elements: one-way pair, then both ways, then reflexive
		set_element_count(7'd2);
		ask_flags();
		put_pair(1, 0);
		ask_flags();
		put_pair(1, 1);
		ask_flags();
		// count above the matrix size saturates; corner pairs of the matrix
		set_element_count(7'd127);
		put_pair(63, 63);
		put_pair(63, 0);
		put_pair(0, 63);
		ask_flags();
		set_element_count(7'd64);
		ask_flags();

		// random phases over growing windows, then a tiny one again
		run_phase(7'd4,   0,  0,  160, 0);
		run_phase(7'd9,   71, 0,  160, 0);
		run_phase(7'd16,  0,  71, 120, 2);
		run_phase(7'd24,  24, 24, 120, 1);
		run_phase(7'd33,  0,  0,  80,  0);
		run_phase(7'd64,  0,  71, 40,  0);
		run_phase(7'd127, 24, 24, 40,  0);
		run_phase(7'd2,   71, 0,  160, 0);

		settle_idle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d input words and %0d flag words", board.words_taken,
			board.flags_seen);
		$display("element counts 0 to 127 with sender gaps, receiver stalls and a long hold-off");
		if (board.mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("Verification failed");
		$finish;
	end

endmodule
